FILE: hdl/gbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbs_pkg;

  localparam int FIELD_W    = 16;
  localparam int BOX_W      = 4 * FIELD_W;
  localparam int ENTRY_W    = BOX_W + FIELD_W;  // box in low bits, score on top
  localparam int THR_W      = 16;
  localparam int KLIM_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_LIMIT        = 2'd1;

  localparam logic [THR_W-1:0]  THR_RESET  = 16'd19661;
  localparam logic [KLIM_W-1:0] KLIM_RESET = 7'd0;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch input beat, ptr <= count
    logic rd_last;    // read lowest-ranked entry
    logic set_ovf;
    logic trim;       // count, ptr <= CAPACITY-1
    logic ins_rd;     // read entry ptr-1
    logic ins_shift;  // entry ptr <= read data, ptr--
    logic ins_place;  // entry ptr <= candidate, count++
    logic sup_init;   // limit, ptr, kept count
    logic sup_rd;     // read entry ptr
    logic j_clr;
    logic kept_rd;    // read kept list at j
    logic ov_start;
    logic j_inc;
    logic sup_skip;   // ptr++
    logic sup_keep;   // append to kept list, ptr++
    logic emit_init;
    logic emit;       // drive one result beat
    logic clear;      // end of frame
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic drop;
    logic ptr_zero;
    logic ins_less;
    logic final_seen;
    logic sup_end;
    logic j_end;
    logic ov_done;
    logic ov_hit;
    logic emit_last;
    logic kept_empty;
  } status_t;

endpackage
`default_nettype wire

FILE: hdl/gbs_overlap.sv
`timescale 1ns / 1ps
`default_nettype none
module gbs_overlap (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [gbs_pkg::BOX_W-1:0]    box_a,
  input  wire logic [gbs_pkg::BOX_W-1:0]    box_b,
  input  wire logic [gbs_pkg::THR_W-1:0]    thr,
  output logic                              done,
  output logic                              hit
);
  import gbs_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld_r, vld_nxt;

  // stage 1: edges
  logic [FIELD_W:0] ax2, ay2, bx2, by2;
  logic [FIELD_W:0] x1_r, y1_r, x2_r, y2_r;
  logic [FIELD_W-1:0] aw_r, ah_r, bw_r, bh_r;
  // stage 2: overlap extents
  logic [FIELD_W:0] iw_r, ih_r;
  logic [FIELD_W-1:0] aw2_r, ah2_r, bw2_r, bh2_r;
  // stage 3: areas
  logic [2*FIELD_W+1:0] inter_r;
  logic [2*FIELD_W-1:0] aa_r, ab_r;
  // stage 4: union
  logic [2*FIELD_W+1:0] inter4_r, uni_r;
  // stage 5: scaled compare operands
  logic [2*FIELD_W+THR_W+1:0] lhs_r, rhs_r;
  logic inz5_r, unz5_r;
  logic hit_r;

  assign ax2 = {1'b0, box_a[15:0]}  + {1'b0, box_a[47:32]};
  assign ay2 = {1'b0, box_a[31:16]} + {1'b0, box_a[63:48]};
  assign bx2 = {1'b0, box_b[15:0]}  + {1'b0, box_b[47:32]};
  assign by2 = {1'b0, box_b[31:16]} + {1'b0, box_b[63:48]};

  assign vld_nxt = {vld_r[STAGES-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x1_r <= (box_a[15:0] > box_b[15:0]) ? {1'b0, box_a[15:0]} : {1'b0, box_b[15:0]};
    y1_r <= (box_a[31:16] > box_b[31:16]) ? {1'b0, box_a[31:16]} : {1'b0, box_b[31:16]};
    x2_r <= (ax2 < bx2) ? ax2 : bx2;
    y2_r <= (ay2 < by2) ? ay2 : by2;
    aw_r <= box_a[47:32];
    ah_r <= box_a[63:48];
    bw_r <= box_b[47:32];
    bh_r <= box_b[63:48];

    iw_r  <= (x2_r > x1_r) ? x2_r - x1_r : '0;
    ih_r  <= (y2_r > y1_r) ? y2_r - y1_r : '0;
    aw2_r <= aw_r;
    ah2_r <= ah_r;
    bw2_r <= bw_r;
    bh2_r <= bh_r;

    inter_r <= iw_r * ih_r;
    aa_r    <= aw2_r * ah2_r;
    ab_r    <= bw2_r * bh2_r;

    // intersection never exceeds either area, so no wrap here
    inter4_r <= inter_r;
    uni_r    <= {2'b00, aa_r} + {2'b00, ab_r} - inter_r;

    lhs_r  <= {inter4_r, {THR_W{1'b0}}};
    rhs_r  <= thr * uni_r;
    inz5_r <= (inter4_r != '0);
    unz5_r <= (uni_r != '0);

    hit_r <= inz5_r && unz5_r && (lhs_r > rhs_r);
  end

  assign done = vld_r[STAGES-1];
  assign hit  = hit_r;

endmodule
`default_nettype wire

FILE: hdl/gbs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module gbs_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire gbs_pkg::cmd_t                     cmd,
  output gbs_pkg::status_t                       status,
  input  wire logic [gbs_pkg::BOX_W-1:0]         in_box,
  input  wire logic [gbs_pkg::FIELD_W-1:0]       in_score,
  input  wire logic                              in_final,
  input  wire logic                              cfg_we,
  input  wire logic [gbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                                   out_valid,
  output logic [gbs_pkg::ENTRY_W-1:0]            out_entry,
  output logic                                   out_last,
  output logic                                   out_ovf
);
  import gbs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > KLIM_W) ? CW : KLIM_W;
  localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
  localparam logic [CW-1:0] CAP_M1 = CW'(CAPACITY - 1);

  logic [ENTRY_W-1:0] main_mem [CAPACITY];
  logic [ENTRY_W-1:0] kept_mem [CAPACITY];
  logic [ENTRY_W-1:0] main_rd_r, kept_rd_r;

  logic [THR_W-1:0]  thr_r;
  logic [KLIM_W-1:0] klim_r;
  logic [CW-1:0]     cnt_r, ptr_r, jdx_r, kcnt_r, lim_r;
  logic              ovf_r;
  logic [BOX_W-1:0]  cand_box_r;
  logic [FIELD_W-1:0] cand_score_r;
  logic              cand_final_r;
  logic              out_valid_r, out_last_r, out_ovf_r;
  logic [ENTRY_W-1:0] out_entry_r;

  logic [CW-1:0]     ptr_m1, jdx_p1, lim_nxt;
  logic [LW-1:0]     klim_ext, cnt_ext;
  logic [AW-1:0]     main_raddr;
  logic              main_re, main_we;
  logic [ENTRY_W-1:0] main_wdata;
  logic              ov_done, ov_hit;

  assign ptr_m1   = ptr_r - 1'b1;
  assign jdx_p1   = jdx_r + 1'b1;
  assign klim_ext = LW'(klim_r);
  assign cnt_ext  = LW'(cnt_r);
  assign lim_nxt  = (klim_r != '0 && klim_ext < cnt_ext) ? CW'(klim_ext) : cnt_r;

  always_comb begin
    priority if (cmd.rd_last) begin
      main_raddr = AW'(CAPACITY - 1);
    end else if (cmd.ins_rd) begin
      main_raddr = ptr_m1[AW-1:0];
    end else begin
      main_raddr = ptr_r[AW-1:0];
    end
  end

  assign main_re    = cmd.rd_last | cmd.ins_rd | cmd.sup_rd;
  assign main_we    = cmd.ins_shift | cmd.ins_place;
  assign main_wdata = cmd.ins_shift ? main_rd_r : {cand_score_r, cand_box_r};

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[ptr_r[AW-1:0]] <= main_wdata;
    end
    if (main_re) begin
      main_rd_r <= main_mem[main_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sup_keep) begin
      kept_mem[kcnt_r[AW-1:0]] <= main_rd_r;
    end
    if (cmd.kept_rd) begin
      kept_rd_r <= kept_mem[jdx_r[AW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      klim_r      <= KLIM_RESET;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == REG_OVERLAP_THRESHOLD) begin
        thr_r <= cfg_wdata[THR_W-1:0];
      end
      if (cfg_we && cfg_index == REG_KEEP_LIMIT) begin
        klim_r <= cfg_wdata[KLIM_W-1:0];
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
      if (cmd.trim) begin
        cnt_r <= CAP_M1;
      end
      if (cmd.ins_place) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.clear) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
      out_valid_r <= cmd.emit;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cand_box_r   <= in_box;
      cand_score_r <= in_score;
      cand_final_r <= in_final;
      ptr_r        <= cnt_r;
    end
    if (cmd.trim) begin
      ptr_r <= CAP_M1;
    end
    if (cmd.ins_shift) begin
      ptr_r <= ptr_m1;
    end
    if (cmd.sup_init) begin
      lim_r  <= lim_nxt;
      ptr_r  <= '0;
      kcnt_r <= '0;
    end
    if (cmd.sup_skip || cmd.sup_keep) begin
      ptr_r <= ptr_r + 1'b1;
    end
    if (cmd.sup_keep) begin
      kcnt_r <= kcnt_r + 1'b1;
    end
    if (cmd.j_clr || cmd.emit_init) begin
      jdx_r <= '0;
    end
    if (cmd.j_inc || cmd.emit) begin
      jdx_r <= jdx_p1;
    end
    if (cmd.emit) begin
      out_entry_r <= kept_rd_r;
      out_last_r  <= (jdx_p1 == kcnt_r);
      out_ovf_r   <= ovf_r;
    end
  end

  gbs_overlap u_overlap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.ov_start),
    .box_a (main_rd_r[BOX_W-1:0]),
    .box_b (kept_rd_r[BOX_W-1:0]),
    .thr   (thr_r),
    .done  (ov_done),
    .hit   (ov_hit)
  );

  always_comb begin
    status.full       = (cnt_r == CAP_C);
    status.drop       = (cand_score_r <= main_rd_r[ENTRY_W-1:BOX_W]);
    status.ptr_zero   = (ptr_r == '0);
    status.ins_less   = (main_rd_r[ENTRY_W-1:BOX_W] < cand_score_r);
    status.final_seen = cand_final_r;
    status.sup_end    = (ptr_r == lim_r);
    status.j_end      = (jdx_r == kcnt_r);
    status.ov_done    = ov_done;
    status.ov_hit     = ov_hit;
    status.emit_last  = (jdx_p1 == kcnt_r);
    status.kept_empty = (kcnt_r == '0);
  end

  assign out_valid = out_valid_r;
  assign out_entry = out_entry_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

endmodule
`default_nettype wire

FILE: hdl/gbs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gbs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire gbs_pkg::status_t  status,
  output gbs_pkg::cmd_t          cmd,
  output logic                   busy
);
  import gbs_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FULL_RD  = 4'd1;
  localparam logic [3:0] S_FULL_CHK = 4'd2;
  localparam logic [3:0] S_INS_RD   = 4'd3;
  localparam logic [3:0] S_INS_CMP  = 4'd4;
  localparam logic [3:0] S_SUP_INIT = 4'd5;
  localparam logic [3:0] S_SUP_NEXT = 4'd6;
  localparam logic [3:0] S_SUP_J    = 4'd7;
  localparam logic [3:0] S_SUP_GO   = 4'd8;
  localparam logic [3:0] S_SUP_WAIT = 4'd9;
  localparam logic [3:0] S_EMIT_RD  = 4'd10;
  localparam logic [3:0] S_EMIT_OUT = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [3:0] post_ins;

  assign post_ins = status.final_seen ? S_SUP_INIT : S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = status.full ? S_FULL_RD : S_INS_RD;
        end
      end
      S_FULL_RD: begin
        cmd.rd_last = 1'b1;
        state_nxt   = S_FULL_CHK;
      end
      S_FULL_CHK: begin
        cmd.set_ovf = 1'b1;
        if (status.drop) begin
          state_nxt = post_ins;
        end else begin
          cmd.trim  = 1'b1;
          state_nxt = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (status.ptr_zero) begin
          cmd.ins_place = 1'b1;
          state_nxt     = post_ins;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status.ins_less) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          state_nxt     = post_ins;
        end
      end
      S_SUP_INIT: begin
        cmd.sup_init = 1'b1;
        state_nxt    = S_SUP_NEXT;
      end
      S_SUP_NEXT: begin
        if (status.sup_end) begin
          if (status.kept_empty) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.emit_init = 1'b1;
            state_nxt     = S_EMIT_RD;
          end
        end else begin
          cmd.sup_rd = 1'b1;
          cmd.j_clr  = 1'b1;
          state_nxt  = S_SUP_J;
        end
      end
      S_SUP_J: begin
        if (status.j_end) begin
          cmd.sup_keep = 1'b1;
          state_nxt    = S_SUP_NEXT;
        end else begin
          cmd.kept_rd = 1'b1;
          state_nxt   = S_SUP_GO;
        end
      end
      S_SUP_GO: begin
        cmd.ov_start = 1'b1;
        state_nxt    = S_SUP_WAIT;
      end
      S_SUP_WAIT: begin
        if (status.ov_done) begin
          if (status.ov_hit) begin
            cmd.sup_skip = 1'b1;
            state_nxt    = S_SUP_NEXT;
          end else begin
            cmd.j_inc = 1'b1;
            state_nxt = S_SUP_J;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.kept_rd = 1'b1;
        state_nxt   = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.emit = 1'b1;
        if (status.emit_last) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

FILE: hdl/greedy_box_suppression_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Greedy box suppression (NMS) for one frame of candidate boxes.
// Input: pulse start with a box beat while busy is low; the beat is taken at
//   that edge. in_final_box marks the frame's last candidate.
// Each beat is sorted into the score store (descending, ties keep arrival
//   order) by walking down from the tail: read the entry above, then shift it
//   down or place the beat. A full store drops its lowest box, or the beat if
//   it scores no higher, and flags overflow; a dropped beat skips the walk.
// After the final beat, candidates (cut to keep_limit, 0 = all) are checked
//   against the kept list one pair at a time through the six-stage IoU
//   pipeline; each pair's result is awaited before another pair starts.
// Results: out_valid is high for one cycle per kept box, in score order;
//   out_last_kept marks the frame's last one. busy drops at the last result.
//   The receiver cannot stall; results are never held.
// Config: cfg_we with cfg_index writes overlap_threshold (0) or keep_limit
//   (1) at once; the user must write only while idle, and the block does
//   not enforce it. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) empties the store and restores the config
//   defaults; no clearing pass is needed.
module greedy_box_suppression_unit #(
  parameter int CAPACITY = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [gbs_pkg::FIELD_W-1:0]       in_box_left,
  input  wire logic [gbs_pkg::FIELD_W-1:0]       in_box_top,
  input  wire logic [gbs_pkg::FIELD_W-1:0]       in_box_width,
  input  wire logic [gbs_pkg::FIELD_W-1:0]       in_box_height,
  input  wire logic [gbs_pkg::FIELD_W-1:0]       in_box_score,
  input  wire logic                              in_final_box,
  output logic                                   out_valid,
  output logic [gbs_pkg::FIELD_W-1:0]            out_kept_left,
  output logic [gbs_pkg::FIELD_W-1:0]            out_kept_top,
  output logic [gbs_pkg::FIELD_W-1:0]            out_kept_width,
  output logic [gbs_pkg::FIELD_W-1:0]            out_kept_height,
  output logic [gbs_pkg::FIELD_W-1:0]            out_kept_score,
  output logic                                   out_last_kept,
  output logic                                   out_overflowed,
  input  wire logic                              cfg_we,
  input  wire logic [gbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [gbs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import gbs_pkg::*;

  cmd_t               cmd;
  status_t            status;
  logic [ENTRY_W-1:0] out_entry;

  // controller: sort walk, suppression loop, result sequencing
  gbs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath: stores, counters, IoU pipeline, config and output registers
  gbs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_box    ({in_box_height, in_box_width, in_box_top, in_box_left}),
    .in_score  (in_box_score),
    .in_final  (in_final_box),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_entry (out_entry),
    .out_last  (out_last_kept),
    .out_ovf   (out_overflowed)
  );

  // entry layout: left, top, width, height from the low bits, score on top
  assign out_kept_left   = out_entry[FIELD_W-1:0];
  assign out_kept_top    = out_entry[2*FIELD_W-1:FIELD_W];
  assign out_kept_width  = out_entry[3*FIELD_W-1:2*FIELD_W];
  assign out_kept_height = out_entry[4*FIELD_W-1:3*FIELD_W];
  assign out_kept_score  = out_entry[5*FIELD_W-1:4*FIELD_W];

endmodule
`default_nettype wire

FILE: hdl/gbs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gbs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_last_kept,
  input wire logic out_overflowed
);

  // an accepted beat always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // results come only out of a frame in progress
  a_result_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside a frame");

  // frame ends with its last result; earlier results keep the block busy
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_kept) |-> !busy)
    else $error("busy after last result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_kept) |-> busy)
    else $error("idle before last result");

  // overflow flag is the same on every result of a frame
  a_ovf_steady: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_kept) |->
      ##2 (out_valid && (out_overflowed == $past(out_overflowed, 2))))
    else $error("overflow flag changed within frame");

endmodule

bind greedy_box_suppression_unit gbs_checker u_gbs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_last_kept  (out_last_kept),
  .out_overflowed (out_overflowed)
);
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the greedy box suppression unit.
// A scoreboard model sorts each accepted beat into its own store and, on the
// frame's final beat, runs greedy suppression to queue the kept boxes.
// A checker compares every out_valid beat with the oldest queued box.
module testbench;
  import gbs_pkg::*;

  localparam int  CAP        = 64;
  localparam int  CYCLE_LIMIT = 2000000;
  // index 2 and 3 map to nothing; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic [FIELD_W-1:0] left, top, width, height;
  } box_t;

  typedef struct packed {
    box_t               box;
    logic [FIELD_W-1:0] score;
    logic               last_kept;
    logic               overflowed;
  } kept_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [FIELD_W-1:0]    in_box_left = '0, in_box_top = '0;
  logic [FIELD_W-1:0]    in_box_width = '0, in_box_height = '0, in_box_score = '0;
  logic                  in_final_box = 1'b0;
  logic                  out_valid;
  logic [FIELD_W-1:0]    out_kept_left, out_kept_top, out_kept_width;
  logic [FIELD_W-1:0]    out_kept_height, out_kept_score;
  logic                  out_last_kept, out_overflowed;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  greedy_box_suppression_unit #(.CAPACITY(CAP)) DUT (.*);

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scoreboard model: sorted store, config copy, queue of expected kept boxes
  // ---------------------------------------------------------------------------
  box_t               sorted_box [CAP];
  logic [FIELD_W-1:0] sorted_score [CAP];
  int                 n_stored;
  bit                 dropped_any;
  logic [THR_W-1:0]   iou_thr = THR_RESET;
  logic [KLIM_W-1:0]  cut_limit = KLIM_RESET;
  kept_t              kept_boxes[$];
  int                 n_errors;
  longint             cycle_count;

  // greedy test, division free: inter*65536 > thr*union
  function automatic bit too_close(box_t a, box_t b);
    longint unsigned ax, ay, aw, ah, bx, by, bw, bh;
    longint unsigned ax2, ay2, bx2, by2, x1, y1, x2, y2, iw, ih, inter, uni;
    ax = 64'(a.left);  ay = 64'(a.top);  aw = 64'(a.width);  ah = 64'(a.height);
    bx = 64'(b.left);  by = 64'(b.top);  bw = 64'(b.width);  bh = 64'(b.height);
    ax2 = ax + aw;  ay2 = ay + ah;
    bx2 = bx + bw;  by2 = by + bh;
    x1 = (ax > bx) ? ax : bx;
    y1 = (ay > by) ? ay : by;
    x2 = (ax2 < bx2) ? ax2 : bx2;
    y2 = (ay2 < by2) ? ay2 : by2;
    iw = (x2 > x1) ? x2 - x1 : 64'd0;
    ih = (y2 > y1) ? y2 - y1 : 64'd0;
    inter = iw * ih;
    if (inter == 0) return 1'b0;
    uni = aw * ah + bw * bh - inter;
    if (uni == 0) return 1'b0;
    return (inter << 16) > 64'(iou_thr) * uni;
  endfunction

  task automatic take_beat(box_t bx, logic [FIELD_W-1:0] sc, bit fin);
    int  pos, lim, last_i;
    bit  keep;
    bit  marks [CAP];
    kept_t k;
    // sorted insertion, lowest dropped when full
    if (n_stored >= CAP) begin
      dropped_any = 1'b1;
      if (sc <= sorted_score[CAP-1]) pos = -1;
      else n_stored = CAP - 1;
    end
    if (n_stored < CAP) begin
      pos = n_stored;
      while (pos > 0 && sorted_score[pos-1] < sc) pos--;
      for (int i = n_stored; i > pos; i--) begin
        sorted_box[i]   = sorted_box[i-1];
        sorted_score[i] = sorted_score[i-1];
      end
      sorted_box[pos]   = bx;
      sorted_score[pos] = sc;
      n_stored++;
    end
    if (!fin) return;
    lim = n_stored;
    if (cut_limit != 0 && int'(cut_limit) < lim) lim = int'(cut_limit);
    last_i = 0;
    for (int i = 0; i < lim; i++) begin
      keep = 1'b1;
      for (int j = 0; j < i && keep; j++)
        if (marks[j] && too_close(sorted_box[i], sorted_box[j])) keep = 1'b0;
      marks[i] = keep;
      if (keep) last_i = i;
    end
    for (int i = 0; i < lim; i++) begin
      if (marks[i]) begin
        k.box        = sorted_box[i];
        k.score      = sorted_score[i];
        k.last_kept  = (i == last_i);
        k.overflowed = dropped_any;
        kept_boxes   = {kept_boxes, k};
      end
    end
    n_stored    = 0;
    dropped_any = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker; the unit cannot be stalled, so every strobe is a beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    kept_t got, want;
    if (rst_n && out_valid) begin
      got.box        = '{out_kept_left, out_kept_top, out_kept_width, out_kept_height};
      got.score      = out_kept_score;
      got.last_kept  = out_last_kept;
      got.overflowed = out_overflowed;
      if (kept_boxes.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        n_errors++;
      end else begin
        want = kept_boxes.pop_front();
        if (got.box.left !== want.box.left)
          $display("%0t: left exp %h got %h", $realtime, want.box.left, got.box.left);
        if (got.box.top !== want.box.top)
          $display("%0t: top exp %h got %h", $realtime, want.box.top, got.box.top);
        if (got.box.width !== want.box.width)
          $display("%0t: width exp %h got %h", $realtime, want.box.width, got.box.width);
        if (got.box.height !== want.box.height)
          $display("%0t: height exp %h got %h", $realtime, want.box.height,
                   got.box.height);
        if (got.score !== want.score)
          $display("%0t: score exp %h got %h", $realtime, want.score, got.score);
        if (got.last_kept !== want.last_kept)
          $display("%0t: last_kept exp %b got %b", $realtime, want.last_kept,
                   got.last_kept);
        if (got.overflowed !== want.overflowed)
          $display("%0t: overflowed exp %b got %b", $realtime, want.overflowed,
                   got.overflowed);
        if (got !== want) n_errors++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them.
  // Called at a rising edge; returns at the edge where the beat was taken,
  // leaving start high so back-to-back beats need no second assignment.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_box(box_t bx, logic [FIELD_W-1:0] sc, bit fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start         <= 1'b1;
    in_box_left   <= bx.left;
    in_box_top    <= bx.top;
    in_box_width  <= bx.width;
    in_box_height <= bx.height;
    in_box_score  <= sc;
    in_final_box  <= fin;
    do @(posedge clk); while (busy !== 1'b0);
    take_beat(bx, sc, fin);
  endtask

  // drains the frame, then lets the unit settle before a config write
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (kept_boxes.size() != 0 || busy !== 1'b0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_OVERLAP_THRESHOLD: iou_thr   = val[THR_W-1:0];
      REG_KEEP_LIMIT:        cut_limit = val[KLIM_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic box_t mk(int l, int t, int w, int h);
    box_t b;
    b.left = 16'(l); b.top = 16'(t); b.width = 16'(w); b.height = 16'(h);
    return b;
  endfunction

  // clustered boxes so suppression actually fires; sometimes full-range bits
  function automatic box_t rand_box();
    box_t b;
    if ($urandom_range(0, 4) == 0) begin
      b = {$urandom, $urandom};
    end else begin
      b.left   = 16'($urandom_range(0, 3) * 32'h1000 + $urandom_range(0, 255));
      b.top    = 16'($urandom_range(0, 3) * 32'h1000 + $urandom_range(0, 255));
      b.width  = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(64, 1024));
      b.height = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(64, 1024));
    end
    return b;
  endfunction

  function automatic logic [FIELD_W-1:0] rand_score();
    // narrow range now and then to force ties
    return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(100, 104)) : 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // single box frame at the field maxima
    send_box(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 16'hFFFF, 1'b1);
    // zeros, identical boxes, tie scores, zero-size, disjoint pair
    send_box(mk(0, 0, 0, 0), 16'h0000, 1'b0);
    send_box(mk(100, 100, 200, 200), 16'h8000, 1'b0);
    send_box(mk(100, 100, 200, 200), 16'h8000, 1'b0);   // tie, identical
    send_box(mk(110, 105, 200, 190), 16'h9000, 1'b0);
    send_box(mk(5000, 5000, 0, 300), 16'hA000, 1'b0);   // zero width
    send_box(mk(5000, 5000, 300, 300), 16'h7000, 1'b0);
    send_box(mk(9000, 9000, 50, 50), 16'h0001, 1'b1);   // disjoint
    wait_idle();
    // overlapping, edge-adjacent and identical boxes with threshold extremes
    write_reg(REG_OVERLAP_THRESHOLD, 16'h0000);
    send_box(mk(0, 0, 400, 400), 16'h5555, 1'b0);
    send_box(mk(399, 399, 10, 10), 16'hAAAA, 1'b0);     // touches by one unit
    send_box(mk(400, 400, 10, 10), 16'h1111, 1'b1);     // edge-adjacent, empty
    wait_idle();
    write_reg(REG_OVERLAP_THRESHOLD, 16'hFFFF);
    send_box(mk(0, 0, 400, 400), 16'h5555, 1'b0);
    send_box(mk(0, 0, 400, 400), 16'h5555, 1'b1);       // IoU one, above max
    wait_idle();
  endtask

  task automatic test_config();
    // unknown index is ignored; keep_limit keeps only its low bits
    write_reg(REG_UNMAPPED, 16'hFFFF);
    write_reg(REG_SPARE, 16'h0000);
    write_reg(REG_OVERLAP_THRESHOLD, THR_RESET);
    write_reg(REG_KEEP_LIMIT, 16'hFF81);                // -> 1
    for (int i = 0; i < 4; i++) send_box(rand_box(), rand_score(), i == 3);
    wait_idle();
    write_reg(REG_KEEP_LIMIT, 16'd64);
    for (int i = 0; i < 3; i++) send_box(rand_box(), rand_score(), i == 2);
    wait_idle();
    write_reg(REG_KEEP_LIMIT, 16'd127);                 // above count, no cut
    for (int i = 0; i < 3; i++) send_box(rand_box(), rand_score(), i == 2);
    wait_idle();
  endtask

  task automatic test_overflow();
    write_reg(REG_KEEP_LIMIT, 16'd0);
    for (int i = 0; i < 70; i++) send_box(rand_box(), rand_score(), i == 69);
    wait_idle();
  endtask

  task automatic test_random();
    int n;
    logic [CFG_DATA_W-1:0] thr_pick [4] = '{16'd0, 16'd19661, 16'd40000, 16'hFFFF};
    for (int f = 0; f < 20; f++) begin
      if (f % 4 == 0) begin
        write_reg(REG_OVERLAP_THRESHOLD,
                  $urandom_range(0, 1) ? thr_pick[f/4 % 4] : 16'($urandom));
        write_reg(REG_KEEP_LIMIT,
                  ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 8)) : 16'd0);
      end
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send_box(rand_box(), rand_score(), i == n - 1);
      if (f % 4 == 3) wait_idle();
    end
    wait_idle();
  endtask

  initial begin
    n_stored    = 0;
    dropped_any = 1'b0;
    n_errors    = 0;
    cycle_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config();
    test_overflow();
    test_random();
    start <= 1'b0;
    repeat (200) @(posedge clk);
    if (n_errors == 0 && kept_boxes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/gbs_pkg.sv
hdl/gbs_overlap.sv
hdl/gbs_datapath.sv
hdl/gbs_ctrl.sv
hdl/greedy_box_suppression_unit.sv
hdl/gbs_checker.sv
sim/testbench.sv
